/* hw/rtl/pcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_pkg: shared types and constants
// Word layouts, command and register codes, sequencer states and divider
// control/status types for the projected coordinate descent core.
// ----------------------------------------------------------------------------
package pcd_pkg;

   localparam int DATA_W       = 32;
   localparam int CSR_AW       = 4;
   localparam int DEF_MAX_ROWS = 16;
   localparam int DEF_MAX_COLS = 64;
   localparam int ACC_W        = 64;
   localparam int DEN_W        = 33;

   // register index = paddr[3:2]
   localparam logic [1:0] REG_GAMMA = 2'd0;
   localparam logic [1:0] REG_ROWS  = 2'd1;
   localparam logic [1:0] REG_COLS  = 2'd2;

   typedef enum logic [1:0] {
      CMD_LOAD_A    = 2'd0,
      CMD_LOAD_CELL = 2'd1,
      CMD_RUN       = 2'd2,
      CMD_READ      = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_FETCH,
      ST_MULY,
      ST_ACCY,
      ST_KRD,
      ST_KMUL,
      ST_KACC,
      ST_DIVINIT,
      ST_DIV,
      ST_WB,
      ST_DONE
   } state_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [3:0]  row;
      logic [5:0]  col;
      logic signed [31:0] a_value;
      logic signed [31:0] y_value;
      logic signed [31:0] b_value;
      logic signed [31:0] lambda_value;
      logic signed [31:0] zone_value;
      logic signed [31:0] start_value;
   } req_type;

   typedef struct packed {
      logic [30:0] x_value;
      logic        done_res;
      logic        div_fault;
      logic        overflow;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic [ACC_W-1:0]   num;
      logic [DEN_W-1:0]   den;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [ACC_W-1:0]   quot;
   } div_rsp_type;

endpackage

/* hw/rtl/pcd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_ram: simple dual-port memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pcd_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/pcd_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_divider: radix-2 restoring divider
// Unsigned 64 / 33 bit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcd_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  pcd_pkg::div_req_type div_req,
   output pcd_pkg::div_rsp_type div_rsp
);
   import pcd_pkg::*;

   localparam int CNT_W = $clog2(ACC_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [DEN_W-1:0]   dvs_ff, dvs_in;
   logic [ACC_W-1:0]   quo_ff, quo_in;
   logic [DEN_W:0]     trial;
   logic               fits;

   // one shift-subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[ACC_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = div_req.den;
         quo_in  = div_req.num;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, dvs_ff}) : DEN_W'(trial);
         quo_in = {quo_ff[ACC_W-2:0], fits};
         cnt_in = CNT_W'(cnt_ff + CNT_W'(1));
         if (cnt_ff == CNT_W'(ACC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign div_rsp = '{busy: busy_ff, done: done_ff, quot: quo_ff};

endmodule

/* hw/rtl/projected_coordinate_descent_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// projected_coordinate_descent_core: projected Gauss-Seidel sweep engine
// Stores A and per-cell data, runs one in-place sweep per run word with one
// shared multiplier and one shared bit-serial divider.
// ----------------------------------------------------------------------------
// Load words: result registered in the cycle after accept. Read word: result
// follows the READ state (RAM read). Run word: per cell, a multiply-accumulate
// per A term (KRD, KMUL, KACC) and a divide (start, one step per bit, done).
// One word in flight at a time; next word taken while the result is drained.
// Synchronous reset clears state, flags, rsp_valid and CSRs, not data or stores.
// ----------------------------------------------------------------------------
module projected_coordinate_descent_core #(
   parameter int MAX_ROWS = pcd_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = pcd_pkg::DEF_MAX_COLS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [pcd_pkg::CSR_AW-1:0] paddr,
   input  logic [pcd_pkg::DATA_W-1:0] pwdata,
   output logic [pcd_pkg::DATA_W-1:0] prdata,
   output logic                       pready,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  pcd_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output pcd_pkg::rsp_type           rsp_data
);
   import pcd_pkg::*;

   localparam int AAW  = (MAX_ROWS * MAX_ROWS > 1) ? $clog2(MAX_ROWS * MAX_ROWS) : 1;
   localparam int CAW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
   localparam int RIW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CIW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int MW   = $clog2(MAX_ROWS + 1);
   localparam int NW   = $clog2(MAX_COLS + 1);
   localparam int CELL_W = 4 * DATA_W;

   // configuration registers
   logic signed [DATA_W-1:0] gamma_ff;
   logic [4:0]               rows_ff;
   logic [6:0]               cols_ff;
   logic                     csr_wr;
   logic [1:0]               csr_idx;

   // sequencer state
   state_type          state_ff, state_in;
   logic [RIW-1:0]     i_ff, i_in, k_ff, k_in;
   logic [CIW-1:0]     j_ff, j_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic signed [ACC_W-1:0] prod_ff;
   logic signed [DATA_W-1:0] mul_a, mul_b;
   logic               nneg_ff, nneg_in, dneg_ff, dneg_in, zero_ff, zero_in;
   logic               rd_ok_ff, rd_ok_in;
   logic               fault_ff, fault_in, sat_ff, sat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // memory ports
   logic               a_we;
   logic [AAW-1:0]     a_waddr, a_raddr;
   logic [DATA_W-1:0]  a_rd;
   logic               cell_we;
   logic [CAW-1:0]     cell_idx, req_cidx, k_cidx;
   logic [CELL_W-1:0]  cell_wdata, cell_rd;
   logic               x_we;
   logic [CAW-1:0]     x_waddr, x_raddr;
   logic [DATA_W-1:0]  x_wdata, x_rd;
   logic signed [DATA_W-1:0] y_rd, b_rd, l_rd, w_rd;

   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic [MW-1:0]      m_eff;
   logic [NW-1:0]      n_eff;
   logic               i_last, k_last, j_last;
   logic               req_fire, a_ok, c_ok;
   logic [DEN_W-1:0]   bl_diff;
   logic [ACC_W-1:0]   quot;

   // ---------------------------------------------------------------------
   // APB register file
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= 32'sd65536;
         rows_ff  <= 5'd16;
         cols_ff  <= 7'd64;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_GAMMA: gamma_ff <= pwdata;
            REG_ROWS:  rows_ff  <= pwdata[4:0];
            REG_COLS:  cols_ff  <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_GAMMA: prdata = gamma_ff;
         REG_ROWS:  prdata = {27'd0, rows_ff};
         REG_COLS:  prdata = {25'd0, cols_ff};
         default:   prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // sizes clamped to the store geometry
   assign m_eff  = (32'(rows_ff) > 32'(MAX_ROWS)) ? MW'(MAX_ROWS) : MW'(rows_ff);
   assign n_eff  = (32'(cols_ff) > 32'(MAX_COLS)) ? NW'(MAX_COLS) : NW'(cols_ff);
   assign i_last = (MW'(i_ff) + MW'(1)) == m_eff;
   assign k_last = (MW'(k_ff) + MW'(1)) == m_eff;
   assign j_last = (NW'(j_ff) + NW'(1)) == n_eff;

   // request decode
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign a_ok = (32'(req_data.row) < 32'(MAX_ROWS)) && (32'(req_data.col) < 32'(MAX_ROWS));
   assign c_ok = (32'(req_data.row) < 32'(MAX_ROWS)) && (32'(req_data.col) < 32'(MAX_COLS));

   // address generation
   assign req_cidx = CAW'(CAW'(req_data.row) * CAW'(MAX_COLS) + CAW'(req_data.col));
   assign cell_idx = CAW'(CAW'(i_ff) * CAW'(MAX_COLS) + CAW'(j_ff));
   assign k_cidx   = CAW'(CAW'(k_ff) * CAW'(MAX_COLS) + CAW'(j_ff));
   assign a_waddr  = AAW'(AAW'(req_data.row) * AAW'(MAX_ROWS) + AAW'(req_data.col));
   assign a_raddr  = (state_ff == ST_FETCH)
                   ? AAW'(AAW'(i_ff) * AAW'(MAX_ROWS) + AAW'(i_ff))
                   : AAW'(AAW'(i_ff) * AAW'(MAX_ROWS) + AAW'(k_ff));

   always_comb begin
      priority case (state_ff)
         ST_IDLE:                   x_raddr = req_cidx;
         ST_KRD, ST_KMUL, ST_KACC:  x_raddr = k_cidx;
         default:                   x_raddr = cell_idx;
      endcase
   end

   assign cell_wdata = {req_data.y_value, req_data.b_value,
                        req_data.lambda_value, req_data.zone_value};
   assign {y_rd, b_rd, l_rd, w_rd} = cell_rd;

   // ---------------------------------------------------------------------
   // stores
   pcd_ram #(.DEPTH(MAX_ROWS * MAX_ROWS), .WIDTH(DATA_W), .AW(AAW)) u_a_ram (
      .clock (clock), .we (a_we), .waddr (a_waddr), .wdata (req_data.a_value),
      .raddr (a_raddr), .rdata (a_rd));

   pcd_ram #(.DEPTH(MAX_ROWS * MAX_COLS), .WIDTH(CELL_W), .AW(CAW)) u_cell_ram (
      .clock (clock), .we (cell_we), .waddr (req_cidx), .wdata (cell_wdata),
      .raddr (cell_idx), .rdata (cell_rd));

   pcd_ram #(.DEPTH(MAX_ROWS * MAX_COLS), .WIDTH(DATA_W), .AW(CAW)) u_x_ram (
      .clock (clock), .we (x_we), .waddr (x_waddr), .wdata (x_wdata),
      .raddr (x_raddr), .rdata (x_rd));

   // shared divider
   pcd_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp));

   // shared multiplier, registered
   assign mul_a = (state_ff == ST_KMUL) ? $signed(a_rd) : gamma_ff;
   assign mul_b = (state_ff == ST_KMUL) ? $signed(x_rd) : y_rd;

   always_ff @(posedge clock) begin
      prod_ff <= ACC_W'(mul_a) * ACC_W'(mul_b);
   end

   assign bl_diff = DEN_W'(DEN_W'(b_rd) - DEN_W'(l_rd));
   assign quot    = div_rsp.quot;

   // ---------------------------------------------------------------------
   // sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      den_in       = den_ff;
      nneg_in      = nneg_ff;
      dneg_in      = dneg_ff;
      zero_in      = zero_ff;
      rd_ok_in     = rd_ok_ff;
      fault_in     = fault_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      a_we         = 1'b0;
      cell_we      = 1'b0;
      x_we         = 1'b0;
      x_waddr      = cell_idx;
      x_wdata      = '0;
      div_req      = '{start: 1'b0, num: acc_ff, den: den_ff};
      if (nneg_ff) begin
         div_req.num = ACC_W'(0) - acc_ff;
      end
      if (dneg_ff) begin
         div_req.den = DEN_W'(0) - den_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_data.cmd)
                  CMD_LOAD_A: begin
                     a_we         = a_ok;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{x_value: '0, done_res: 1'b1,
                                      div_fault: fault_ff, overflow: sat_ff};
                  end
                  CMD_LOAD_CELL: begin
                     cell_we      = c_ok;
                     x_we         = c_ok;
                     x_waddr      = req_cidx;
                     x_wdata      = req_data.start_value;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{x_value: '0, done_res: 1'b1,
                                      div_fault: fault_ff, overflow: sat_ff};
                  end
                  CMD_RUN: begin
                     i_in = '0;
                     j_in = '0;
                     if (m_eff == '0 || n_eff == '0) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
                  CMD_READ: begin
                     rd_ok_in = c_ok;
                     state_in = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            // negative stored X reads as zero
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{x_value: (rd_ok_ff && !x_rd[31]) ? x_rd[30:0] : '0,
                             done_res: 1'b1, div_fault: fault_ff, overflow: sat_ff};
            state_in     = ST_IDLE;
         end
         ST_FETCH: state_in = ST_MULY;
         ST_MULY: begin
            // gamma*y goes to the multiplier; (b - lambda) << 16 seeds acc
            den_in   = DEN_W'($signed(a_rd)) + DEN_W'(w_rd);
            acc_in   = {{(ACC_W - DEN_W){bl_diff[DEN_W-1]}}, bl_diff} << 16;
            k_in     = '0;
            state_in = ST_ACCY;
         end
         ST_ACCY: begin
            acc_in   = acc_ff + prod_ff;
            state_in = ST_KRD;
         end
         ST_KRD:  state_in = ST_KMUL;
         ST_KMUL: state_in = ST_KACC;
         ST_KACC: begin
            // the diagonal term cancels against +a_ii*x_ij
            if (k_ff != i_ff) begin
               acc_in = acc_ff - prod_ff;
            end
            if (k_last) begin
               state_in = ST_DIVINIT;
            end else begin
               k_in     = RIW'(k_ff + RIW'(1));
               state_in = ST_KRD;
            end
         end
         ST_DIVINIT: begin
            nneg_in = acc_ff[ACC_W-1];
            dneg_in = den_ff[DEN_W-1];
            if (den_ff == '0) begin
               fault_in = 1'b1;
               zero_in  = 1'b1;
               state_in = ST_WB;
            end else begin
               zero_in  = 1'b0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // start issued on entry; signs are registered by now
            div_req.start = !div_rsp.busy && !div_rsp.done && !zero_ff;
            if (div_rsp.done) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            x_we    = 1'b1;
            x_waddr = cell_idx;
            if (zero_ff || nneg_ff != dneg_ff) begin
               x_wdata = '0;
            end else if (|quot[ACC_W-1:31]) begin
               x_wdata = 32'h7FFF_FFFF;
               sat_in  = 1'b1;
            end else begin
               x_wdata = {1'b0, quot[30:0]};
            end
            if (i_last) begin
               i_in = '0;
               if (j_last) begin
                  state_in = ST_DONE;
               end else begin
                  j_in     = CIW'(j_ff + CIW'(1));
                  state_in = ST_FETCH;
               end
            end else begin
               i_in     = RIW'(i_ff + RIW'(1));
               state_in = ST_FETCH;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{x_value: '0, done_res: 1'b1,
                             div_fault: fault_ff, overflow: sat_ff};
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fault_ff     <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fault_ff     <= fault_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      acc_ff      <= acc_in;
      den_ff      <= den_in;
      nneg_ff     <= nneg_in;
      dneg_ff     <= dneg_in;
      zero_ff     <= zero_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // assertions
   a_run_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.cmd == CMD_RUN) |=> (state_ff != ST_IDLE))
      else $error("run word did not start the sweep");

   a_div_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> div_rsp.busy)
      else $error("divider did not take the start");

   a_wb_nonneg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WB) |-> !x_wdata[31])
      else $error("negative X written back");

   a_sat_sticky: assert property (@(posedge clock) disable iff (reset)
      sat_ff |=> sat_ff)
      else $error("overflow flag cleared without reset");

endmodule

/* tb/sv/projected_coordinate_descent_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// projected_coordinate_descent_core_tb: self-checking bench for the sweep core
// Loads coupling and cell data, runs Gauss-Seidel sweeps and reads X back.
// A scoreboard class models the stores, flags and the sweep arithmetic and
// checks every response word field by field; both sides idle at random early.
// ----------------------------------------------------------------------------
module projected_coordinate_descent_core_tb;
   import pcd_pkg::*;

   // Sweep model and queue of predicted response words
   class coord_sweep_scoreboard;
      logic signed [31:0] amat [16][16];
      logic signed [31:0] ys [16][64];
      logic signed [31:0] bs [16][64];
      logic signed [31:0] lams [16][64];
      logic signed [31:0] zones [16][64];
      logic signed [31:0] xs [16][64];
      bit                 a_loaded [16][16];
      bit                 cell_loaded [16][64];
      bit                 fault;
      bit                 sat;
      logic signed [31:0] gamma_q;
      int                 rows_cfg;
      int                 cols_cfg;
      rsp_type            pending_rsp [$];
      int                 errors;

      function new();
         gamma_q  = 32'sh0001_0000;
         rows_cfg = 16;
         cols_cfg = 64;
         errors   = 0;
      endfunction

      function int eff_rows();
         return (rows_cfg > 16) ? 16 : rows_cfg;
      endfunction

      function int eff_cols();
         return (cols_cfg > 64) ? 64 : cols_cfg;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] v);
         case (idx)
            REG_GAMMA: gamma_q = v;
            REG_ROWS:  rows_cfg = v[4:0];
            REG_COLS:  cols_cfg = v[6:0];
            default: ;
         endcase
      endfunction

      // one cell update: Q32.32 numerator, truncating divide, clamp at zero
      function logic [31:0] relax_cell(int i, int j, int m);
         bit [63:0] acc;
         bit [63:0] nmag;
         bit [63:0] dmag;
         bit [63:0] q;
         longint    aii;
         longint    den;
         aii = longint'(amat[i][i]);
         acc = longint'(gamma_q) * longint'(ys[i][j]);
         acc += longint'(bs[i][j]) <<< 16;
         acc -= longint'(lams[i][j]) <<< 16;
         for (int k = 0; k < m; k++)
            acc -= longint'(amat[i][k]) * longint'(xs[k][j]);
         acc += aii * longint'(xs[i][j]);
         den = aii + longint'(zones[i][j]);
         if (den == 0) begin
            fault = 1;
            return 32'd0;
         end
         nmag = acc[63] ? -acc : acc;
         dmag = (den < 0) ? -den : den;
         q = nmag / dmag;
         if (acc[63] != (den < 0))
            return 32'd0;
         if (q > 64'h7FFF_FFFF) begin
            sat = 1;
            return 32'h7FFF_FFFF;
         end
         return q[31:0];
      endfunction

      function void note_word(req_type w);
         rsp_type r;
         int      m;
         int      n;
         r = '0;
         case (w.cmd)
            CMD_LOAD_A: begin
               if (w.col < 16) begin
                  amat[w.row][w.col] = w.a_value;
                  a_loaded[w.row][w.col] = 1;
               end
            end
            CMD_LOAD_CELL: begin
               ys[w.row][w.col]    = w.y_value;
               bs[w.row][w.col]    = w.b_value;
               lams[w.row][w.col]  = w.lambda_value;
               zones[w.row][w.col] = w.zone_value;
               xs[w.row][w.col]    = w.start_value;
               cell_loaded[w.row][w.col] = 1;
            end
            CMD_RUN: begin
               m = eff_rows();
               n = eff_cols();
               for (int j = 0; j < n; j++)
                  for (int i = 0; i < m; i++)
                     xs[i][j] = relax_cell(i, j, m);
            end
            default: begin
               if (!xs[w.row][w.col][31])
                  r.x_value = xs[w.row][w.col][30:0];
            end
         endcase
         r.done_res  = 1'b1;
         r.div_fault = fault;
         r.overflow  = sat;
         pending_rsp.push_back(r);
      endfunction

      function void check_word(rsp_type r);
         rsp_type e;
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: response word with none expected: %h", $realtime, r);
            return;
         end
         e = pending_rsp.pop_front();
         if (r.x_value !== e.x_value || r.done_res !== e.done_res ||
             r.div_fault !== e.div_fault || r.overflow !== e.overflow) begin
            errors++;
            if (errors <= 10)
               $display("%0t: mismatch x %h/%h done %b/%b fault %b/%b ovf %b/%b (exp/act)",
                        $realtime, e.x_value, r.x_value, e.done_res, r.done_res,
                        e.div_fault, r.div_fault, e.overflow, r.overflow);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_AW-1:0]     paddr;
   logic [DATA_W-1:0]     pwdata;
   logic [DATA_W-1:0]     prdata;
   logic                  pready;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;

   coord_sweep_scoreboard sb;
   int                    send_idle;
   int                    recv_idle;
   bit                    pressure_go;

   projected_coordinate_descent_core DUT (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog
   initial begin
      #40_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // accepted words and responses go to the scoreboard
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_word(req_data);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word(rsp_data);
   end

   // receiver: random stalls, plus one long hold-off when asked
   initial begin
      int  hold_left;
      bit  pressure_done;
      hold_left = 0;
      pressure_done = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (pressure_go && !pressure_done) begin
            pressure_done = 1;
            hold_left = 400;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // Q16.16 operand mix: small, extreme or fully random
   function automatic logic [31:0] pick_q();
      case ($urandom_range(3))
         0: return $urandom();
         1: begin
            case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return $urandom_range(32'h7FFFF) - 32'h40000;
      endcase
   endfunction

   function automatic req_type make_word(cmd_type c, int r, int k);
      req_type w;
      w.cmd          = c;
      w.row          = 4'(r);
      w.col          = 6'(k);
      w.a_value      = pick_q();
      w.y_value      = pick_q();
      w.b_value      = pick_q();
      w.lambda_value = pick_q();
      w.zone_value   = pick_q();
      w.start_value  = pick_q();
      return w;
   endfunction

   // called at a negedge context; returns at the accepting posedge
   task automatic send_word(req_type w);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_cell(int r, int k, logic [31:0] y, logic [31:0] b,
                            logic [31:0] l, logic [31:0] z, logic [31:0] s);
      req_type w;
      w = make_word(CMD_LOAD_CELL, r, k);
      w.y_value = y;
      w.b_value = b;
      w.lambda_value = l;
      w.zone_value = z;
      w.start_value = s;
      send_word(w);
   endtask

   task automatic send_coupling(int r, int k, logic [31:0] v);
      req_type w;
      w = make_word(CMD_LOAD_A, r, k);
      w.a_value = v;
      send_word(w);
   endtask

   // drop valid and let everything drain before touching registers
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] v);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= v;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_reg(idx, v);
   endtask

   task automatic configure(logic [31:0] g, int r, int k);
      drain();
      csr_write(REG_GAMMA, g);
      csr_write(REG_ROWS, 32'(r));
      csr_write(REG_COLS, 32'(k));
   endtask

   // load every A entry and cell the next sweep will touch
   task automatic fill_region();
      int m;
      int n;
      m = sb.eff_rows();
      n = sb.eff_cols();
      for (int i = 0; i < m; i++)
         for (int k = 0; k < m; k++)
            if (!sb.a_loaded[i][k])
               send_word(make_word(CMD_LOAD_A, i, k));
      for (int i = 0; i < m; i++)
         for (int j = 0; j < n; j++)
            if (!sb.cell_loaded[i][j])
               send_word(make_word(CMD_LOAD_CELL, i, j));
   endtask

   // random traffic inside the active region, with some stray addresses
   task automatic random_phase(int count);
      int      m;
      int      n;
      int      r;
      int      k;
      int      sel;
      req_type w;
      m = (sb.eff_rows() == 0) ? 1 : sb.eff_rows();
      n = (sb.eff_cols() == 0) ? 1 : sb.eff_cols();
      for (int it = 0; it < count; it++) begin
         sel = $urandom_range(99);
         r = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(m - 1);
         k = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(n - 1);
         if (sel < 28) begin
            w = make_word(CMD_LOAD_A, r, ($urandom_range(4) == 0) ? $urandom_range(63) :
                          $urandom_range(m - 1));
         end else if (sel < 58) begin
            w = make_word(CMD_LOAD_CELL, r, k);
            // aim some cells at a zero denominator
            if (sb.a_loaded[r][r] && $urandom_range(5) == 0)
               w.zone_value = -sb.amat[r][r];
         end else if (sel < 68) begin
            w = make_word(CMD_RUN, r, k);
         end else begin
            w = make_word(sb.cell_loaded[r][k] ? CMD_READ : CMD_LOAD_CELL, r, k);
         end
         send_word(w);
      end
   endtask

   initial begin
      req_type w;
      sb = new();
      reset       = 1'b1;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      req_valid   = 1'b0;
      req_data    = '0;
      send_idle   = 29;
      recv_idle   = 57;
      pressure_go = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: 2x2 grid covering zero denominator, saturation,
      // negative quotient, negative start, stray A column
      configure(32'h0001_0000, 2, 2);
      send_coupling(0, 0, 32'h0001_0000);
      send_coupling(0, 1, 32'h8000_0000);
      send_coupling(1, 0, 32'h7FFF_FFFF);
      send_coupling(1, 1, 32'h0001_0000);
      send_coupling(3, 40, 32'h1234_5678);
      send_cell(0, 0, 32'h0, 32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'h7FFF_FFFF);
      send_cell(1, 0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_0001, 32'h0);
      send_cell(0, 1, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0001_0000, 32'h8000_0000);
      send_cell(1, 1, 32'h0002_0000, 32'h0000_8000, 32'h0, 32'h0001_0000, 32'h0001_0000);
      send_word(make_word(CMD_READ, 0, 1));
      send_word(make_word(CMD_READ, 0, 0));
      send_word(make_word(CMD_RUN, 0, 0));
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            send_word(make_word(CMD_READ, i, j));
      send_word(make_word(CMD_RUN, 0, 0));
      send_word(make_word(CMD_READ, 1, 1));

      // random phases: size settings including the extremes
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: configure($urandom(), 3, 4);
            1: configure(32'h8000_0000, 16, 1);
            2: configure(32'h7FFF_FFFF, 1, 64);
            3: configure(32'h0, 0, 127);
            4: configure($urandom(), 31, 1);
            5: configure($urandom(), 4, 3);
            default: configure(32'h0001_0000, 2, 5);
         endcase
         if (ph < 2) begin
            send_idle = 29;
            recv_idle = 57;
         end else if (ph < 4) begin
            send_idle = 57;
            recv_idle = 29;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         fill_region();
         if (ph == 5)
            pressure_go = 1'b1;
         random_phase(30);
      end

      drain();
      repeat (40) @(negedge clock);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
